// ----- hdl/rtcsp_pkg.sv -----
// shared types and constants for the three-wire rtc serial port
// no dependencies

package rtcsp_pkg;

  // default number of bytes in the transfer buffer
  localparam int unsigned BufferBytesDef = 7;

  localparam int unsigned CmdBits = 4;

  // register select codes (command bits 3..1)
  localparam logic [2:0] RegStatus = 3'd0;
  localparam logic [2:0] RegClock  = 3'd1;
  localparam logic [2:0] RegAlarm  = 3'd2;

  // transfer lengths in bytes
  localparam logic [2:0] LenStatus = 3'd1;
  localparam logic [2:0] LenClock  = 3'd7;
  localparam logic [2:0] LenAlarm  = 3'd2;
  localparam logic [2:0] LenNone   = 3'd0;

  // status word returned for every port write
  typedef struct packed {
    logic       data_out;
    logic       read_active;
    logic       command_ready;
    logic [2:0] byte_position;
    logic       selected;
  } result_t;

  function automatic logic [2:0] reg_length(input logic [2:0] sel);
    logic [2:0] len;
    case (sel)
      RegStatus: len = LenStatus;
      RegClock:  len = LenClock;
      RegAlarm:  len = LenAlarm;
      default:   len = LenNone;
    endcase
    return len;
  endfunction

endpackage

// ----- hdl/rtcsp_core.sv -----
// transfer state machine and byte buffer of the three-wire rtc serial port
// depends on rtcsp_pkg

module rtcsp_core import rtcsp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] port_value_i,
  output result_t    result_o
);

  localparam int unsigned IdxW = $clog2(BUFFER_BYTES);
  localparam int unsigned CmpW = IdxW + 1;

  logic       sel_q, sel_d;
  logic       prev_clk_q, prev_clk_d;
  logic [3:0] cmd_q, cmd_d;
  logic [2:0] cmd_cnt_q, cmd_cnt_d;
  logic [2:0] len_q, len_d;
  logic [2:0] byte_cnt_q, byte_cnt_d;
  logic [2:0] bit_cnt_q, bit_cnt_d;
  logic       read_q, read_d;
  logic       out_bit_q, out_bit_d;
  logic [7:0] buf_q [BUFFER_BYTES];
  logic [7:0] buf_d [BUFFER_BYTES];

  logic            sdata, sclk, cs;
  logic [IdxW-1:0] idx;
  logic [7:0]      cur_byte;
  logic            in_range;

  assign sdata = port_value_i[0];
  assign sclk  = port_value_i[1];
  assign cs    = port_value_i[4];
  assign idx   = IdxW'(byte_cnt_q);
  assign in_range = (CmpW'(byte_cnt_q) < CmpW'(BUFFER_BYTES));
  assign cur_byte = in_range ? buf_q[idx] : 8'h00;

  always_comb begin
    sel_d      = sel_q;
    prev_clk_d = prev_clk_q;
    cmd_d      = cmd_q;
    cmd_cnt_d  = cmd_cnt_q;
    len_d      = len_q;
    byte_cnt_d = byte_cnt_q;
    bit_cnt_d  = bit_cnt_q;
    read_d     = read_q;
    out_bit_d  = out_bit_q;
    buf_d      = buf_q;
    if (!cs || !sel_q) begin
      // deselect or fresh select: clear transfer, keep the buffer
      sel_d      = cs;
      prev_clk_d = cs & sclk;
      cmd_d      = '0;
      cmd_cnt_d  = '0;
      len_d      = '0;
      byte_cnt_d = '0;
      bit_cnt_d  = '0;
      read_d     = 1'b0;
      out_bit_d  = 1'b0;
    end else begin
      prev_clk_d = sclk;
      if (sclk && !prev_clk_q) begin
        if (cmd_cnt_q < 3'(CmdBits)) begin
          cmd_d     = {cmd_q[2:0], sdata};
          cmd_cnt_d = cmd_cnt_q + 3'd1;
          if (cmd_cnt_q == 3'(CmdBits - 1)) begin
            read_d     = cmd_d[0];
            len_d      = reg_length(cmd_d[3:1]);
            byte_cnt_d = '0;
            bit_cnt_d  = '0;
          end
        end else if (byte_cnt_q < len_q && in_range) begin
          if (read_q) begin
            out_bit_d = cur_byte[~bit_cnt_q];
          end else begin
            buf_d[idx] = {cur_byte[6:0], sdata};
          end
          bit_cnt_d = bit_cnt_q + 3'd1;
          if (bit_cnt_q == 3'd7) begin
            byte_cnt_d = byte_cnt_q + 3'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q      <= 1'b0;
      prev_clk_q <= 1'b0;
      cmd_q      <= '0;
      cmd_cnt_q  <= '0;
      len_q      <= '0;
      byte_cnt_q <= '0;
      bit_cnt_q  <= '0;
      read_q     <= 1'b0;
      out_bit_q  <= 1'b0;
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        buf_q[i] <= '0;
      end
    end else if (accept_i) begin
      sel_q      <= sel_d;
      prev_clk_q <= prev_clk_d;
      cmd_q      <= cmd_d;
      cmd_cnt_q  <= cmd_cnt_d;
      len_q      <= len_d;
      byte_cnt_q <= byte_cnt_d;
      bit_cnt_q  <= bit_cnt_d;
      read_q     <= read_d;
      out_bit_q  <= out_bit_d;
      buf_q      <= buf_d;
    end
  end

  // status after this write
  assign result_o.data_out      = out_bit_d;
  assign result_o.read_active   = read_d;
  assign result_o.command_ready = (cmd_cnt_d >= 3'(CmdBits));
  assign result_o.byte_position = byte_cnt_d;
  assign result_o.selected      = sel_d;

endmodule

// ----- hdl/rtc_three_wire_serial_port_unit.sv -----
// top level of the three-wire rtc serial port, slave side
// depends on rtcsp_pkg and rtcsp_core

// usage
//   input channel: one port byte per word (bit 0 serial data, bit 1 serial
//   clock, bit 4 chip select), handshake in_valid_i / in_stall_o
//   output channel: one status word per input word, handshake
//   out_valid_o / out_stall_i, fields data_out, read_active,
//   command_ready, byte_position and selected
// output path: the status word of a taken port byte is registered into the
//   output register, or into the skid register if the output word waits
// throughput: one word per cycle unless stalled; the protocol state update
//   is one shift, count and compare level feeding the state registers
// stall: a two-entry output stage (output register plus skid register)
//   keeps taking input while one result waits; in_stall_o rises only when
//   both entries are full and is driven straight from a register
// reset: all transfer state, the byte buffer and both output entries are
//   cleared; the buffer is not cleared when chip select drops, so a read
//   returns what earlier writes left behind
// transfer: four command bits MSB first on rising serial clock edges, then
//   the selected number of data bytes, MSB first, into or out of the buffer

module rtc_three_wire_serial_port_unit import rtcsp_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = BufferBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] port_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       data_out_o,
  output logic       read_active_o,
  output logic       command_ready_o,
  output logic [2:0] byte_position_o,
  output logic       selected_o
);

  logic    accept;
  logic    out_fire;
  result_t result;

  // output register and skid register
  logic    out_valid_q;
  result_t out_q;
  logic    skid_valid_q;
  result_t skid_q;

  assign accept   = in_valid_i && !skid_valid_q;
  assign out_fire = out_valid_q && !out_stall_i;

  rtcsp_core #(
    .BUFFER_BYTES(BUFFER_BYTES)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .port_value_i(port_value_i),
    .result_o    (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
      out_q        <= '0;
      skid_q       <= '0;
    end else begin
      if (accept) begin
        // skid is empty here
        if (!out_valid_q || out_fire) begin
          out_q       <= result;
          out_valid_q <= 1'b1;
        end else begin
          skid_q       <= result;
          skid_valid_q <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_q) begin
          out_q        <= skid_q;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= 1'b0;
        end
      end
    end
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign data_out_o      = out_q.data_out;
  assign read_active_o   = out_q.read_active;
  assign command_ready_o = out_q.command_ready;
  assign byte_position_o = out_q.byte_position;
  assign selected_o      = out_q.selected;

endmodule

// ----- tb/sv/tb_rtc_three_wire_serial_port_unit.sv -----
// testbench for the three-wire rtc serial port, slave side
// drives port bytes through the input handshake and checks every status word
// against an in-bench protocol model or typed rows; uses rtcsp_pkg, unit rtl

module tb_rtc_three_wire_serial_port_unit import rtcsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // bit positions inside the port byte
  localparam int unsigned PortData = 0;
  localparam int unsigned PortSclk = 1;
  localparam int unsigned PortCs   = 4;

  localparam int CycleLimit     = 200000;
  localparam int WordsPerPhase  = 460;
  localparam int PrintCap       = 40;
  localparam int DrainCycles    = 8;

  localparam result_t StatusIdle = '0;
  localparam result_t StatusSelected = '{
    data_out: 1'b0, read_active: 1'b0, command_ready: 1'b0,
    byte_position: 3'd0, selected: 1'b1
  };

  // one row of the directed part: port byte, whether the status is typed in,
  // and the typed status (ignored when the model supplies it)
  typedef struct packed {
    logic [7:0] port;
    logic       typed;
    result_t    status;
  } stim_row_t;

  localparam int DirectedRows = 25;

  localparam stim_row_t DirectedStim [DirectedRows] = '{
    // deselected after reset, everything reads zero
    '{8'h00, 1'b1, StatusIdle},
    // all bits high: select rises with the serial clock already high
    '{8'hFF, 1'b1, StatusSelected},
    // all bits high except select: transfer state clears
    '{8'hEF, 1'b1, StatusIdle},
    // select rises with the clock low
    '{8'h10, 1'b1, StatusSelected},
    // clock stays low, nothing shifts
    '{8'h10, 1'b1, StatusSelected},
    // read command on the clock register: bits 0 0 1 1
    '{8'h12, 1'b0, StatusIdle},
    '{8'h10, 1'b0, StatusIdle},
    '{8'h12, 1'b0, StatusIdle},
    '{8'h10, 1'b0, StatusIdle},
    '{8'h13, 1'b0, StatusIdle},
    // fourth command bit, decode to a seven byte read
    '{8'h11, 1'b0, StatusIdle},
    '{8'h13, 1'b0, StatusIdle},
    // clock held high, no new rising edge
    '{8'h13, 1'b0, StatusIdle},
    '{8'h00, 1'b1, StatusIdle},
    // write command on a register with no length: bits 1 1 1 0
    '{8'h10, 1'b1, StatusSelected},
    '{8'h13, 1'b0, StatusIdle},
    '{8'h11, 1'b0, StatusIdle},
    '{8'h13, 1'b0, StatusIdle},
    '{8'h11, 1'b0, StatusIdle},
    '{8'h13, 1'b0, StatusIdle},
    '{8'h10, 1'b0, StatusIdle},
    '{8'h12, 1'b0, StatusIdle},
    // a further edge moves no data
    '{8'h11, 1'b0, StatusIdle},
    '{8'h13, 1'b0, StatusIdle},
    '{8'h00, 1'b1, StatusIdle}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] port_value_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic       data_out_o;
  logic       read_active_o;
  logic       command_ready_o;
  logic [2:0] byte_position_o;
  logic       selected_o;

  rtc_three_wire_serial_port_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .port_value_i   (port_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .data_out_o     (data_out_o),
    .read_active_o  (read_active_o),
    .command_ready_o(command_ready_o),
    .byte_position_o(byte_position_o),
    .selected_o     (selected_o)
  );

  // protocol model state, all zero after reset
  logic       sel_q;
  logic       prev_sclk;
  logic [3:0] cmd_sr;
  logic [2:0] cmd_cnt;
  logic [2:0] xfer_len;
  logic [2:0] byte_cnt;
  logic [2:0] bit_cnt;
  logic       rd_mode;
  logic       dout_bit;
  logic [7:0] buf_mem [BufferBytesDef];

  result_t pending_status [$];
  int      mismatch_count;
  int      words_sent;
  int      cycle_count;
  int      idle_pct;
  int      stall_pct;

  // 4 ns clock, high then low
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // run guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver side: random stall, changed only at the falling edge
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic report_mismatch(input string what, input int got_v, input int exp_v);
    mismatch_count++;
    if (mismatch_count <= PrintCap)
      $display("%0t ns: %s got %0d expected %0d", $time, what, got_v, exp_v);
  endtask

  task automatic clear_xfer();
    cmd_sr   = '0;
    cmd_cnt  = '0;
    xfer_len = '0;
    byte_cnt = '0;
    bit_cnt  = '0;
    rd_mode  = 1'b0;
    dout_bit = 1'b0;
  endtask

  // advance the protocol model by one port byte and return its status word
  task automatic predict_status(input logic [7:0] pb, output result_t st);
    logic sd;
    logic sc;
    logic cs;
    sd = pb[PortData];
    sc = pb[PortSclk];
    cs = pb[PortCs];
    if (!cs) begin
      // deselect: transfer state clears, buffer is kept
      sel_q = 1'b0;
      clear_xfer();
      prev_sclk = 1'b0;
    end else if (!sel_q) begin
      // select rising: fresh transfer, no edge acted on this word
      sel_q = 1'b1;
      clear_xfer();
      prev_sclk = sc;
    end else begin
      if (sc && !prev_sclk) begin
        if (cmd_cnt < CmdBits) begin
          cmd_sr  = {cmd_sr[2:0], sd};
          cmd_cnt = cmd_cnt + 3'd1;
          if (cmd_cnt == CmdBits) begin
            rd_mode = cmd_sr[0];
            case (cmd_sr[3:1])
              RegStatus: xfer_len = LenStatus;
              RegClock:  xfer_len = LenClock;
              RegAlarm:  xfer_len = LenAlarm;
              default:   xfer_len = LenNone;
            endcase
            byte_cnt = '0;
            bit_cnt  = '0;
          end
        end else if (byte_cnt < xfer_len && byte_cnt < BufferBytesDef) begin
          // data phase, msb first
          if (rd_mode)
            dout_bit = buf_mem[byte_cnt][3'd7 - bit_cnt];
          else
            buf_mem[byte_cnt] = {buf_mem[byte_cnt][6:0], sd};
          if (bit_cnt == 3'd7) begin
            bit_cnt  = '0;
            byte_cnt = byte_cnt + 3'd1;
          end else begin
            bit_cnt = bit_cnt + 3'd1;
          end
        end
      end
      prev_sclk = sc;
    end
    st.data_out      = dout_bit;
    st.read_active   = rd_mode;
    st.command_ready = (cmd_cnt >= CmdBits);
    st.byte_position = byte_cnt;
    st.selected      = sel_q;
  endtask

  // present one port word, hold it until taken, then queue its status
  task automatic send_port(input logic [7:0] pb, input logic typed, input result_t typed_st);
    result_t st;
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    port_value_i <= pb;
    do @(posedge clk_i); while (in_stall_o);
    predict_status(pb, st);
    pending_status.push_back(typed ? typed_st : st);
    words_sent++;
  endtask

  // serial lines with random junk on the unused port bits
  task automatic send_wire(input logic cs, input logic sc, input logic sd);
    logic [7:0] pb;
    pb           = 8'($urandom);
    pb[PortCs]   = cs;
    pb[PortSclk] = sc;
    pb[PortData] = sd;
    send_port(pb, 1'b0, StatusIdle);
  endtask

  // one transfer: select, command, data bits, deselect; sometimes broken
  task automatic run_transfer();
    logic [2:0] reg_sel;
    logic [3:0] cmd;
    logic [2:0] len;
    int         nbits;
    if ($urandom_range(99) < 6) begin
      // raw noise on every bit
      repeat ($urandom_range(1, 6)) send_port(8'($urandom), 1'b0, StatusIdle);
      return;
    end
    reg_sel = ($urandom_range(9) < 8) ? 3'($urandom_range(2)) : 3'($urandom_range(7));
    cmd     = {reg_sel, 1'($urandom_range(1))};
    // select rises with the clock at either level
    send_wire(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
    for (int i = 3; i >= 0; i--) begin
      send_wire(1'b1, 1'b0, 1'($urandom_range(1)));
      send_wire(1'b1, 1'b1, cmd[i]);
      // clock held high for an extra word
      if ($urandom_range(19) == 0)
        send_wire(1'b1, 1'b1, 1'($urandom_range(1)));
    end
    case (reg_sel)
      RegStatus: len = LenStatus;
      RegClock:  len = LenClock;
      RegAlarm:  len = LenAlarm;
      default:   len = LenNone;
    endcase
    // a few edges past the end reach the transfer-complete case
    nbits = 8 * int'(len) + $urandom_range(3);
    if ($urandom_range(9) == 0)
      nbits = $urandom_range(nbits);
    repeat (nbits) begin
      send_wire(1'b1, 1'b0, 1'($urandom_range(1)));
      send_wire(1'b1, 1'b1, 1'($urandom_range(1)));
    end
    repeat ($urandom_range(1, 3))
      send_wire(1'b0, 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  // status checker
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{
        data_out: data_out_o, read_active: read_active_o,
        command_ready: command_ready_o, byte_position: byte_position_o,
        selected: selected_o
      };
      if (pending_status.size() == 0) begin
        report_mismatch("status word with none pending", int'(got), -1);
      end else begin
        want = pending_status.pop_front();
        if (got.data_out !== want.data_out)
          report_mismatch("data_out", got.data_out, want.data_out);
        if (got.read_active !== want.read_active)
          report_mismatch("read_active", got.read_active, want.read_active);
        if (got.command_ready !== want.command_ready)
          report_mismatch("command_ready", got.command_ready, want.command_ready);
        if (got.byte_position !== want.byte_position)
          report_mismatch("byte_position", got.byte_position, want.byte_position);
        if (got.selected !== want.selected)
          report_mismatch("selected", got.selected, want.selected);
      end
    end
  end

  initial begin
    int phase_idle [4];
    int phase_stall [4];
    int target;
    // phases: no idling, sender idle, receiver stalling, both
    phase_idle  = '{0, 73, 0, 36};
    phase_stall = '{0, 0, 73, 36};
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    port_value_i   = '0;
    out_stall_i    = 1'b0;
    mismatch_count = 0;
    words_sent     = 0;
    cycle_count    = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    sel_q          = 1'b0;
    prev_sclk      = 1'b0;
    clear_xfer();
    foreach (buf_mem[i]) buf_mem[i] = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int r = 0; r < DirectedRows; r++)
      send_port(DirectedStim[r].port, DirectedStim[r].typed, DirectedStim[r].status);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = phase_idle[ph];
      stall_pct = phase_stall[ph];
      target    = words_sent + WordsPerPhase;
      while (words_sent < target) run_transfer();
      // sender holds off until every pending status word is back
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      while (pending_status.size() != 0) @(posedge clk_i);
    end

    stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_status.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
